>>> src/positional_list_engine_macros.svh
// assertion macros for the positional list engine
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// implication or plain property checked on every clock outside reset
`define PLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition that must never be seen outside reset
`define PLE_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PLE_ASSERT(label, prop, msg)
`define PLE_ASSERT_NEVER(label, cond, msg)
`endif

`endif

>>> src/ple_pkg.sv
`default_nettype none

package ple_pkg;

  localparam int unsigned CAPACITY_DEF = 128;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 8;

  // per-cell command broadcast along the row
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SET,
    CELL_INS,
    CELL_DEL,
    CELL_LOAD,
    CELL_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [POS_W-1:0] pos;
    logic [DATA_W-1:0] val;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> src/ple_cell.sv
`default_nettype none

module ple_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 8
) (
  input  wire logic                          clk_i,
  input  wire ple_pkg::cell_ctrl_t           ctrl_i,
  input  wire logic [CNT_W-1:0]              count_i,
  input  wire logic [ple_pkg::DATA_W-1:0]    left_i,
  input  wire logic [ple_pkg::DATA_W-1:0]    right_i,
  input  wire logic [ple_pkg::DATA_W-1:0]    shadow_right_i,
  output logic      [ple_pkg::DATA_W-1:0]    entry_o,
  output logic      [ple_pkg::DATA_W-1:0]    shadow_o
);

  logic [ple_pkg::DATA_W-1:0] entry_q, entry_d;
  logic [ple_pkg::DATA_W-1:0] shadow_q, shadow_d;
  logic at_pos, from_left, from_right;
  logic ins_span, del_span;

  // 1-based position compare against this cell's own slot
  assign at_pos     = (32'(ctrl_i.pos) == 32'(IDX) + 32'd1);
  assign from_left  = (32'(IDX) >= 32'(ctrl_i.pos));
  assign from_right = (32'(IDX) + 32'd1 >= 32'(ctrl_i.pos));
  // only cells up to one past the old last entry move up, cells further out keep their value
  assign ins_span   = (32'(IDX) <= 32'(count_i));
  // the old last cell keeps its value on a shift down
  assign del_span   = (32'(IDX) + 32'd2 <= 32'(count_i));

  always_comb begin
    entry_d  = entry_q;
    shadow_d = shadow_q;
    case (ctrl_i.op)
      ple_pkg::CELL_SET: begin
        if (at_pos) entry_d = ctrl_i.val;
      end
      ple_pkg::CELL_INS: begin
        if (at_pos) begin
          entry_d = ctrl_i.val;
        end else if (from_left && ins_span) begin
          entry_d = left_i;
        end
      end
      ple_pkg::CELL_DEL: begin
        if (from_right && del_span) entry_d = right_i;
      end
      ple_pkg::CELL_LOAD:  shadow_d = entry_q;
      ple_pkg::CELL_SHIFT: shadow_d = shadow_right_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q  <= entry_d;
    shadow_q <= shadow_d;
  end

  assign entry_o  = entry_q;
  assign shadow_o = shadow_q;

endmodule

`default_nettype wire

>>> src/positional_list_engine.sv
// positional list engine: bounded list of signed 32-bit entries in a row of cells
// init, set, insert, delete and bad-position or full results: registered in the next cycle
// get and locate: shadow chain snapshot, scanned toward cell 0 to target, match or list end
// throughput: one request per cycle if results drain, without a scan; one at a time otherwise
// reset (rst_ni low, asynchronous): length zero, no result pending; entries stay unwritten
`default_nettype none

`include "positional_list_engine_macros.svh"

module positional_list_engine #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request: [2:0] opcode, [34:3] item_value, [42:35] position, [47:43] zero
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,
  // result: [1:0] status, [33:2] read_value, [41:34] found_position,
  //         [49:42] list_length, [55:50] zero
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [55:0] m_axis_tdata_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned DW   = ple_pkg::DATA_W;
  localparam int unsigned PW   = ple_pkg::POS_W;

  // opcodes
  localparam logic [2:0] OpInit   = 3'd0;
  localparam logic [2:0] OpSet    = 3'd1;
  localparam logic [2:0] OpInsert = 3'd2;
  localparam logic [2:0] OpDelete = 3'd3;
  localparam logic [2:0] OpLocate = 3'd4;
  localparam logic [2:0] OpGet    = 3'd5;

  // status codes
  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatFull   = 2'd1;
  localparam logic [1:0] StatBadPos = 2'd2;

  // controller states
  localparam logic SIdle = 1'b0;
  localparam logic SScan = 1'b1;

  // request fields
  logic [2:0]    in_op;
  logic [DW-1:0] in_val;
  logic [PW-1:0] in_pos;
  logic          in_acc;

  assign in_op  = s_axis_tdata_i[2:0];
  assign in_val = s_axis_tdata_i[34:3];
  assign in_pos = s_axis_tdata_i[42:35];

  // control state
  logic            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;

  // scan context and result payload
  logic            is_get_q, is_get_d;
  logic [DW-1:0]   val_q, val_d;
  logic [PW-1:0]   tgt_q, tgt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] idx_inc;
  logic [1:0]      status_q, status_d;
  logic [DW-1:0]   rd_q, rd_d;
  logic [PW-1:0]   found_q, found_d;
  logic [PW-1:0]   len_q, len_d;

  logic            pos_bad;   // position outside 1..length
  logic            ins_ok;    // insert that changes the list

  ple_pkg::cell_ctrl_t cell_ctrl;

  // row of cells
  logic [DW-1:0] entry  [CAPACITY];
  logic [DW-1:0] shadow [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left, right, shadow_right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right        = '0;
      assign shadow_right = '0;
    end else begin : g_mid_r
      assign right        = entry[i+1];
      assign shadow_right = shadow[i+1];
    end

    ple_cell #(
      .IDX   (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (cell_ctrl),
      .count_i        (count_q),
      .left_i         (left),
      .right_i        (right),
      .shadow_right_i (shadow_right),
      .entry_o        (entry[i]),
      .shadow_o       (shadow[i])
    );
  end

  assign s_axis_tready_o = (state_q == SIdle) && (!out_valid_q || m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign pos_bad = (in_pos == '0) || (32'(in_pos) > 32'(count_q));
  assign idx_inc = idx_q + CntW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    is_get_d    = is_get_q;
    val_d       = val_q;
    tgt_d       = tgt_q;
    idx_d       = idx_q;
    status_d    = status_q;
    rd_d        = rd_q;
    found_d     = found_q;
    len_d       = len_q;
    ins_ok      = 1'b0;

    cell_ctrl.op  = ple_pkg::CELL_HOLD;
    cell_ctrl.pos = in_pos;
    cell_ctrl.val = in_val;

    // result taken downstream
    if (out_valid_q && m_axis_tready_i) out_valid_d = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (in_acc) begin
          status_d    = StatOk;
          rd_d        = '0;
          found_d     = '0;
          out_valid_d = 1'b1;
          unique case (in_op)
            OpInit: begin
              if (32'(in_pos) > CAPACITY) begin
                status_d = StatBadPos;
              end else begin
                count_d = CntW'(in_pos);
              end
            end
            OpSet: begin
              if (pos_bad) begin
                status_d = StatBadPos;
              end else begin
                cell_ctrl.op = ple_pkg::CELL_SET;
              end
            end
            OpInsert: begin
              if (32'(count_q) >= CAPACITY) begin
                status_d = StatFull;
              end else if (in_pos == '0 || 32'(in_pos) > 32'(count_q) + 32'd1) begin
                status_d = StatBadPos;
              end else begin
                ins_ok       = 1'b1;
                cell_ctrl.op = ple_pkg::CELL_INS;
                count_d      = count_q + CntW'(1);
              end
            end
            OpDelete: begin
              if (pos_bad) begin
                status_d = StatBadPos;
              end else begin
                cell_ctrl.op = ple_pkg::CELL_DEL;
                count_d      = count_q - CntW'(1);
              end
            end
            OpLocate: begin
              // empty list answers at once, otherwise snapshot and scan
              if (count_q != '0) begin
                cell_ctrl.op = ple_pkg::CELL_LOAD;
                out_valid_d  = 1'b0;
                state_d      = SScan;
                is_get_d     = 1'b0;
                val_d        = in_val;
                idx_d        = '0;
              end
            end
            OpGet: begin
              if (pos_bad) begin
                status_d = StatBadPos;
              end else begin
                cell_ctrl.op = ple_pkg::CELL_LOAD;
                out_valid_d  = 1'b0;
                state_d      = SScan;
                is_get_d     = 1'b1;
                tgt_d        = in_pos - PW'(1);
                idx_d        = '0;
              end
            end
            default: ;  // unused opcodes only report the length
          endcase
          len_d = PW'(count_d);
        end
      end
      SScan: begin
        // shadow of cell 0 holds entry idx_q
        if (is_get_q) begin
          if (32'(idx_q) == 32'(tgt_q)) begin
            rd_d        = shadow[0];
            out_valid_d = 1'b1;
            state_d     = SIdle;
          end else begin
            cell_ctrl.op = ple_pkg::CELL_SHIFT;
            idx_d        = idx_inc;
          end
        end else begin
          if (shadow[0] == val_q) begin
            found_d     = PW'(idx_inc);
            out_valid_d = 1'b1;
            state_d     = SIdle;
          end else if (idx_inc == count_q) begin
            found_d     = '0;
            out_valid_d = 1'b1;
            state_d     = SIdle;
          end else begin
            cell_ctrl.op = ple_pkg::CELL_SHIFT;
            idx_d        = idx_inc;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_get_q <= is_get_d;
    val_q    <= val_d;
    tgt_q    <= tgt_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    rd_q     <= rd_d;
    found_q  <= found_d;
    len_q    <= len_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, len_q, found_q, rd_q, status_q};

  // a successful insert grows the list by exactly one
  `PLE_ASSERT(a_insert_grows, ins_ok |=> (count_q == $past(count_q) + CntW'(1)), "insert did not grow list")
  // the scan index stays inside the current list
  `PLE_ASSERT(a_scan_in_range, (state_q == SScan) |-> (idx_q < count_q), "scan index past list end")
  // a pending result reports the length the list has now
  `PLE_ASSERT(a_len_matches, out_valid_q |-> (len_q == PW'(count_q)), "reported length stale")
  // no request is taken while a scan runs
  `PLE_ASSERT_NEVER(a_no_accept_in_scan, (state_q == SScan) && in_acc, "request taken during scan")

endmodule

`default_nettype wire
